// ----- rtl/core/three_class_priority_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the three-class priority queue unit
// Shorthand for clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef THREE_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define THREE_CLASS_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define TCPQ_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcpq check failed");

// Next-cycle implication, disabled while reset is high
`define TCPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcpq check failed");

`endif

// ----- rtl/core/tcpq_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpq_pkg
// Types and codes shared by the three-class priority queue unit.
// ----------------------------------------------------------------------------
package tcpq_pkg;

  localparam int NUM_CLASSES = 3;
  localparam int CLASS_W     = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;

  // command codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_rd;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_hit;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/core/tcpq_if.sv -----
// ----------------------------------------------------------------------------
// tcpq_in_if / tcpq_out_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface tcpq_in_if import tcpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [CLASS_W-1:0]        class_sel;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, command, class_sel, value, input ready);
  modport sink   (input valid, command, class_sel, value, output ready);
endinterface

interface tcpq_out_if import tcpq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic [CLASS_W-1:0]        class_out;
  logic signed [VALUE_W-1:0] value_out;

  modport source (output valid, status, class_out, value_out, input ready);
  modport sink   (input valid, status, class_out, value_out, output ready);
endinterface

// ----- rtl/core/tcpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcpq_ctrl
// Sequencer: take a word, execute it, wait on the entry read for a dequeue.
// ----------------------------------------------------------------------------
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.out_free) state_next = stat.pop_hit ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = (state == ST_IDLE);
    cmd.load_in = (state == ST_IDLE) && in_valid;
    cmd.exec    = (state == ST_EXEC) && stat.out_free;
    cmd.load_rd = (state == ST_READ);
  end

endmodule

// ----- rtl/core/tcpq_datapath.sv -----
// ----------------------------------------------------------------------------
// tcpq_datapath
// Queue pointers, entry memory and the result register.
// ----------------------------------------------------------------------------
module tcpq_datapath import tcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_cmd_t                  cmd,
  output dp_stat_t                  stat,
  input  logic                      command,
  input  logic [CLASS_W-1:0]        class_sel,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic [CLASS_W-1:0]        class_out,
  output logic signed [VALUE_W-1:0] value_out
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);

  // latched request word
  logic                      cmd_r;
  logic [CLASS_W-1:0]        cls_r;
  logic signed [VALUE_W-1:0] val_r;

  logic [PW-1:0] head [NUM_CLASSES];
  logic [PW-1:0] tail [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] occ;

  logic signed [VALUE_W-1:0] mem [NUM_CLASSES][QUEUE_DEPTH];
  logic signed [VALUE_W-1:0] rd_data;
  logic [CLASS_W-1:0]        pop_cls_r;

  logic                 pop_hit;
  logic [CLASS_W-1:0]   pop_cls;
  logic                 enq_known;
  logic                 enq_occ;
  logic [PW-1:0]        enq_tail;
  logic                 enq_ok;
  logic [PW-1:0]        enq_slot;
  logic                 out_free;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r <= command;
      cls_r <= class_sel;
      val_r <= value;
    end
  end

  // lowest class number that holds something wins
  always_comb begin
    priority if (occ[0]) pop_cls = CLASS_W'(0);
    else if (occ[1])     pop_cls = CLASS_W'(1);
    else                 pop_cls = CLASS_W'(2);
  end

  always_comb begin
    enq_known = 1'b0;
    enq_occ   = 1'b0;
    enq_tail  = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cls_r == CLASS_W'(c)) begin
        enq_known = 1'b1;
        enq_occ   = occ[c];
        enq_tail  = tail[c];
      end
    end
    pop_hit  = (cmd_r == CMD_DEQ) && (|occ);
    enq_ok   = (cmd_r == CMD_ENQ) && enq_known && !(enq_occ && (enq_tail == LAST_SLOT));
    enq_slot = enq_occ ? enq_tail + PW'(1) : '0;
    out_free = !out_valid || out_ready;
  end

  assign stat.pop_hit  = pop_hit;
  assign stat.out_free = out_free;

  // pointer update
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
      end
    end else if (cmd.exec) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (enq_ok && cls_r == CLASS_W'(c)) begin
          occ[c]  <= 1'b1;
          tail[c] <= enq_slot;
          if (!occ[c]) head[c] <= '0;
        end
        if (pop_hit && pop_cls == CLASS_W'(c)) begin
          if (head[c] == tail[c]) begin
            occ[c]  <= 1'b0;
            head[c] <= '0;
            tail[c] <= '0;
          end else begin
            head[c] <= head[c] + PW'(1);
          end
        end
      end
    end
  end

  // entry memory: one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && enq_ok) begin
      mem[cls_r][enq_slot] <= val_r;
    end
    if (cmd.exec && pop_hit) begin
      rd_data   <= mem[pop_cls][head[pop_cls]];
      pop_cls_r <= pop_cls;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_rd || (cmd.exec && !pop_hit)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_rd) begin
      status    <= STAT_DEQUEUED;
      class_out <= pop_cls_r;
      value_out <= rd_data;
    end else if (cmd.exec && !pop_hit) begin
      value_out <= '0;
      priority if (cmd_r == CMD_DEQ) begin
        status    <= STAT_EMPTY;
        class_out <= '0;
      end else if (enq_ok) begin
        status    <= STAT_ENQUEUED;
        class_out <= cls_r;
      end else begin
        status    <= STAT_FULL;
        class_out <= cls_r;
      end
    end
  end

endmodule

// ----- rtl/core/three_class_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// three_class_priority_queue_unit
// Three linear queues of signed words served in strict priority order.
// ----------------------------------------------------------------------------
//  channel | dir | fields                              | word
//  --------+-----+-------------------------------------+---------------------
//  req     | in  | command, class_sel, value           | one operation
//  rsp     | out | status, class_out, value_out        | one result per req
//
//  Steps: an enqueue, a refusal or an all-empty dequeue is latched on
//  acceptance and then executed into the result register; a dequeue that
//  finds a value first goes through the registered read of the entry memory.
//  Reset clears the occupancy flags and pointers; the entry memory is not
//  cleared, so no word is held back after reset.
//  A result waiting on rsp does not block acceptance of the next req word;
//  execution of that word holds until the result register is free.
// ----------------------------------------------------------------------------
module three_class_priority_queue_unit import tcpq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  tcpq_in_if.sink   req,
  tcpq_out_if.source rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;
  logic     in_ready;

  // sequencer: owns the request handshake
  tcpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // datapath: pointers, entries and the result register driving rsp
  tcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .command   (req.command),
    .class_sel (req.class_sel),
    .value     (req.value),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .class_out (rsp.class_out),
    .value_out (rsp.value_out)
  );

endmodule

// ----- rtl/core/tcpq_checker.sv -----
// ----------------------------------------------------------------------------
// tcpq_checker
// Port-level checks on the priority queue unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_class_priority_queue_unit_macros.svh"

module tcpq_checker import tcpq_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_ready,
  input logic                      rsp_valid,
  input logic                      rsp_ready,
  input logic [STATUS_W-1:0]       rsp_status,
  input logic [CLASS_W-1:0]        rsp_class_out,
  input logic signed [VALUE_W-1:0] rsp_value_out
);

  // hold a stalled result word
  `TCPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value_out) && $stable(rsp_status))
  // value only on a dequeue
  `TCPQ_ASSERT_SAME(a_value_zero, clk, rst, rsp_valid && rsp_status != STAT_DEQUEUED, rsp_value_out == '0)
  // all-empty reports class zero
  `TCPQ_ASSERT_SAME(a_empty_class, clk, rst, rsp_valid && rsp_status == STAT_EMPTY, rsp_class_out == '0)
  // one word in flight: drop ready after taking a word
  `TCPQ_ASSERT_NEXT(a_one_in_flight, clk, rst, req_valid && req_ready, !req_ready)

endmodule

bind three_class_priority_queue_unit tcpq_checker u_tcpq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_status    (rsp.status),
  .rsp_class_out (rsp.class_out),
  .rsp_value_out (rsp.value_out)
);

// ----- tb/sv/tb_three_class_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// tb_three_class_priority_queue_unit
// Self-checking bench for the three-class strict-priority queue unit. Words
// go in on the request channel and are mirrored by a behavioural copy of the
// three linear queues, which predicts one result per word. A monitor compares
// every response word, field by field, with the oldest prediction. Both
// channels idle at random, and the response side is held off for a long
// stretch once, so that the unit fills up and pushes back on its input.
// ----------------------------------------------------------------------------
module tb_three_class_priority_queue_unit import tcpq_pkg::*; ();

  localparam int QUEUE_DEPTH = 16;
  localparam int RUN_LIMIT   = 6_000_000;

  // class codes as seen on the request channel
  localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_NONE = 2'd3;

  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [CLASS_W-1:0]        class_out;
    logic signed [VALUE_W-1:0] value_out;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tcpq_in_if  req_ch ();
  tcpq_out_if rsp_ch ();

  three_class_priority_queue_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow copy of the three queues. The slot array is only read between a
  // queue's head and tail, so slots never written are never looked at.
  // --------------------------------------------------------------------------
  logic signed [VALUE_W-1:0] shadow_slot [NUM_CLASSES][QUEUE_DEPTH];
  int                        shadow_head [NUM_CLASSES];
  int                        shadow_tail [NUM_CLASSES];
  bit                        shadow_busy [NUM_CLASSES];

  queue_result_t expected_words[$];   // predicted response words, oldest first
  int            mismatch_count = 0;
  int            words_sent     = 0;
  bit            calm           = 1'b0;  // set: no idling on either side
  int            hold_request   = 0;     // cycles the response side must stall

  // Apply one operation to the shadow queues and return the response word it
  // should produce.
  function automatic queue_result_t apply_queue_op(
    input logic                      cmd,
    input logic [CLASS_W-1:0]        cls,
    input logic signed [VALUE_W-1:0] val
  );
    queue_result_t r;
    bit            found;
    r.status    = STAT_EMPTY;
    r.class_out = '0;
    r.value_out = '0;
    found       = 1'b0;
    if (cmd == CMD_ENQ) begin
      r.class_out = cls;
      if (cls >= NUM_CLASSES) begin
        // unused class code names no queue: refuse, touch nothing
        r.status = STAT_FULL;
      end else if (shadow_busy[cls] && shadow_tail[cls] == QUEUE_DEPTH - 1) begin
        // linear queue: a tail on the last slot refuses until fully drained
        r.status = STAT_FULL;
      end else begin
        if (!shadow_busy[cls]) begin
          shadow_head[cls] = 0;
          shadow_tail[cls] = 0;
          shadow_busy[cls] = 1'b1;
        end else begin
          shadow_tail[cls]++;
        end
        shadow_slot[cls][shadow_tail[cls]] = val;
        r.status = STAT_ENQUEUED;
      end
    end else begin
      // serve the highest-priority queue that holds anything
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!found && shadow_busy[c]) begin
          found       = 1'b1;
          r.status    = STAT_DEQUEUED;
          r.class_out = c[CLASS_W-1:0];
          r.value_out = shadow_slot[c][shadow_head[c]];
          if (shadow_head[c] == shadow_tail[c]) begin
            shadow_busy[c] = 1'b0;
            shadow_head[c] = 0;
            shadow_tail[c] = 0;
          end else begin
            shadow_head[c]++;
          end
        end
      end
    end
    return r;
  endfunction

  // Mostly uniform values, with the extremes and the all-ones pattern mixed in.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side. Offer one word, hold it until the handshake completes, then
  // record its prediction. Valid is left high so that a following word can go
  // straight on; park_request drops it when the stream pauses.
  // --------------------------------------------------------------------------
  task automatic send_word(
    input logic                      cmd,
    input logic [CLASS_W-1:0]        cls,
    input logic signed [VALUE_W-1:0] val
  );
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.command   <= cmd;
    req_ch.class_sel <= cls;
    req_ch.value     <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_words.push_back(apply_queue_op(cmd, cls, val));
    words_sent++;
  endtask

  task automatic park_request();
    req_ch.valid <= 1'b0;
  endtask

  task automatic send_dequeue();
    send_word(CMD_DEQ, CLASS_W'($urandom_range(0, 3)), $urandom());
  endtask

  // --------------------------------------------------------------------------
  // Response side. Stall in random bursts, or for one long stretch when a
  // test asks for it; otherwise keep ready high.
  // --------------------------------------------------------------------------
  initial begin : rsp_ready_gen
    int n;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        n            = hold_request;
        hold_request = 0;
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted response word with the oldest prediction.
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("response word with nothing outstanding: status %0d class %0d value %0d",
               rsp_ch.status, rsp_ch.class_out, rsp_ch.value_out);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.class_out !== want.class_out) begin
          $error("class_out: expected %0d, got %0d", want.class_out, rsp_ch.class_out);
          mismatch_count++;
        end
        if (rsp_ch.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, rsp_ch.value_out);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Dequeue with every queue empty, and an enqueue naming the unused class.
  task automatic test_empty_and_bad_class();
    send_word(CMD_DEQ, CLASS_LOW, VAL_MAX);
    send_word(CMD_ENQ, CLASS_NONE, VAL_MIN);
  endtask

  // A lone low-class word is passed over for a middle-class one; draining
  // the middle queue's last word sends it back to slot zero.
  task automatic test_priority_order();
    send_word(CMD_ENQ, CLASS_LOW, VAL_MIN);
    send_word(CMD_ENQ, CLASS_MID, VAL_MAX);
    send_word(CMD_DEQ, CLASS_HIGH, '0);
  endtask

  // Fill the high queue to its last slot, see the next word refused, then
  // free the head slot and see it refused again: the queue does not wrap.
  // The queues are left loaded for the random traffic that follows.
  task automatic test_full_refusal();
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       send_word(CMD_ENQ, CLASS_HIGH, VAL_MIN);
        1:       send_word(CMD_ENQ, CLASS_HIGH, VAL_MAX);
        2:       send_word(CMD_ENQ, CLASS_HIGH, '0);
        3:       send_word(CMD_ENQ, CLASS_HIGH, '1);
        4:       send_word(CMD_ENQ, CLASS_HIGH, 32'sh5555_5555);
        5:       send_word(CMD_ENQ, CLASS_HIGH, 32'shaaaa_aaaa);
        default: send_word(CMD_ENQ, CLASS_HIGH, $urandom());
      endcase
    end
    send_word(CMD_ENQ, CLASS_HIGH, 32'sh1234_5678);
    send_word(CMD_DEQ, CLASS_HIGH, '0);
    send_word(CMD_ENQ, CLASS_HIGH, 32'sh7654_3210);
  endtask

  // Bursts of well-formed traffic: runs of enqueues to one class, runs of
  // dequeues and mixed stretches, with a little noise on the unused class
  // code.
  task automatic run_traffic(input int count);
    int target;
    int n;
    int cls;
    target = words_sent + count;
    while (words_sent < target) begin
      n = $urandom_range(1, 20);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          cls = $urandom_range(0, NUM_CLASSES - 1);
          repeat (n) send_word(CMD_ENQ, cls[CLASS_W-1:0], pick_value());
        end
        3, 4, 5: begin
          repeat (n) send_dequeue();
        end
        6, 7, 8: begin
          repeat (n) begin
            if ($urandom_range(0, 99) < 55) begin
              send_word(CMD_ENQ, CLASS_W'($urandom_range(0, NUM_CLASSES - 1)),
                        pick_value());
            end else begin
              send_dequeue();
            end
          end
        end
        default: begin
          send_word(CMD_ENQ, CLASS_NONE, pick_value());
        end
      endcase
    end
  endtask

  task automatic test_random_traffic(input int count);
    run_traffic(count);
  endtask

  // Stall the response side for a long stretch while words keep coming, so
  // the unit's result and input registers fill and it drops req.ready.
  task automatic test_backpressure(input int count);
    hold_request = 250;
    run_traffic(count);
  endtask

  // Closing stretch with no idling on either side; the unit still takes each word only once the last is done.
  task automatic test_calm_tail(input int count);
    calm = 1'b1;
    run_traffic(count);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    req_ch.valid     <= 1'b0;
    req_ch.command   <= CMD_ENQ;
    req_ch.class_sel <= CLASS_HIGH;
    req_ch.value     <= '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      shadow_head[c] = 0;
      shadow_tail[c] = 0;
      shadow_busy[c] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_bad_class();
    test_priority_order();
    test_full_refusal();
    test_random_traffic(600);
    test_backpressure(40);
    test_calm_tail(90);
    park_request();

    // drain what is outstanding, then leave the unit running so that a stray response word is caught
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard stop should the unit hang on either handshake.
  initial begin : run_limit
    #RUN_LIMIT;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
